// ===== rtl/core/cbpe_pkg.sv =====
// Package: widths, constants and payload types of the cubic Bezier point evaluator.
package cbpe_pkg;

    localparam int COORD_W    = 24;
    localparam int STEP_W     = 17;
    localparam int IDX_W      = 8;
    localparam int T_W        = STEP_W + IDX_W;
    localparam int NUM_PTS    = 4;
    localparam int PIPE_DEPTH = 7;
    localparam int IN_DATA_W  = 2 * NUM_PTS * COORD_W + IDX_W;
    localparam int OUT_DATA_W = 2 * COORD_W;

    localparam logic [STEP_W-1:0] T_ONE      = 17'h10000;
    localparam logic [STEP_W-1:0] STEP_RESET = 17'd655;
    localparam int                ROUND_HALF = 1 << 23;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [NUM_PTS-1:0][COORD_W-1:0] x;
        logic [NUM_PTS-1:0][COORD_W-1:0] y;
    } ctrl_pts_t;

endpackage

// ===== rtl/core/cubic_bezier_point_eval_core.sv =====
// Top level: pipelined cubic Bezier point evaluator with stream in/out and step size register.
//
// Usage:
//   s_axis carries one curve sample request per transaction: four control points
//   (signed Q16.8) and a step index. The parameter t = step_index * step_size (Q1.16).
//   m_axis returns the curve point (signed Q16.8, saturated) per request, in order;
//   m_axis_tuser is set when t exceeds 1.0, and the point is then zero.
//   The cfg channel writes step_size (unsigned Q1.16); cfg_ready is always high.
//   Write it only while no request is in flight.
// Timing:
//   Seven register stages (t product, u/t squares, cubic terms, weights,
//   weighted coordinates, pair sums, round and saturate). Throughput is one
//   point per cycle while m_axis_tready stays high.
// Reset:
//   rst_n clears all stage valid bits and loads step_size with 655 (about 0.01).
// Backpressure:
//   When m_axis_tready is low, the output holds and the stages behind it
//   close up their bubbles; s_axis_tready drops only when every stage is full.
module cubic_bezier_point_eval_core
    import cbpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [STEP_W-1:0]     cfg_data,      // step_size
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y, step_index
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // point_x, point_y
    output logic                  m_axis_tuser   // past_end
);

    logic [STEP_W-1:0]     step_size_reg;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH:0]   stage_en;

    ctrl_pts_t             pts_in;
    logic [IDX_W-1:0]      step_index;

    ctrl_pts_t             pts1_reg;
    logic [T_W-1:0]        t1_reg;
    logic [T_W-1:0]        t1_next;

    ctrl_pts_t             pts2_reg;
    logic                  past2_reg;
    logic [STEP_W-1:0]     u2_reg;
    logic [STEP_W-1:0]     t2_reg;
    logic [32:0]           uu2_reg;
    logic [32:0]           tt2_reg;
    logic                  past2_next;
    logic [STEP_W-1:0]     u2_next;
    logic [STEP_W-1:0]     t2_next;
    logic [32:0]           uu2_next;
    logic [32:0]           tt2_next;

    ctrl_pts_t             pts3_reg;
    logic                  past3_reg;
    logic [48:0]           c_reg    [NUM_PTS];
    logic [48:0]           c_next   [NUM_PTS];

    ctrl_pts_t             pts4_reg;
    logic                  past4_reg;
    logic [24:0]           w_reg    [NUM_PTS];
    logic [24:0]           w_next   [NUM_PTS];
    logic [49:0]           wsum     [NUM_PTS];

    logic                  past5_reg;
    logic signed [49:0]    prodx_reg  [NUM_PTS];
    logic signed [49:0]    prody_reg  [NUM_PTS];
    logic signed [49:0]    prodx_next [NUM_PTS];
    logic signed [49:0]    prody_next [NUM_PTS];

    logic                  past6_reg;
    logic signed [50:0]    sumx_reg  [2];
    logic signed [50:0]    sumy_reg  [2];
    logic signed [50:0]    sumx_next [2];
    logic signed [50:0]    sumy_next [2];

    logic                  past7_reg;
    coord_t                point_x_reg;
    coord_t                point_y_reg;
    coord_t                point_x_next;
    coord_t                point_y_next;
    logic [51:0]           accx;
    logic [51:0]           accy;

    function automatic coord_t sat_coord(input logic [27:0] r);
        coord_t res;
        if ((r[27:23] == 5'b00000) || (r[27:23] == 5'b11111))
        begin
            res = r[23:0];
        end
        else if (r[27])
        begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    // Unpack the request
    always_comb
    begin
        for (int i = 0; i < NUM_PTS; i++)
        begin
            pts_in.x[i] = s_axis_tdata[2*COORD_W*i +: COORD_W];
            pts_in.y[i] = s_axis_tdata[2*COORD_W*i + COORD_W +: COORD_W];
        end
        step_index = s_axis_tdata[IN_DATA_W-1 -: IDX_W];
    end

    // Advance a stage when it is empty or the one ahead moves
    always_comb
    begin
        stage_en[PIPE_DEPTH] = m_axis_tready;
        for (int k = PIPE_DEPTH - 1; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign s_axis_tready = stage_en[0];
    assign cfg_ready     = 1'b1;

    // Stage datapath
    always_comb
    begin
        t1_next = T_W'(step_index) * T_W'(step_size_reg);

        past2_next = t1_reg > T_W'(T_ONE);
        t2_next    = t1_reg[STEP_W-1:0];
        u2_next    = T_ONE - t1_reg[STEP_W-1:0];
        uu2_next   = 33'(u2_next) * 33'(u2_next);
        tt2_next   = 33'(t2_next) * 33'(t2_next);

        c_next[0] = 49'(uu2_reg) * 49'(u2_reg);
        c_next[1] = 49'(uu2_reg) * 49'(t2_reg);
        c_next[2] = 49'(tt2_reg) * 49'(u2_reg);
        c_next[3] = 49'(tt2_reg) * 49'(t2_reg);

        wsum[0] = 50'(c_reg[0]) + 50'(ROUND_HALF);
        wsum[1] = (50'(c_reg[1]) << 1) + 50'(c_reg[1]) + 50'(ROUND_HALF);
        wsum[2] = (50'(c_reg[2]) << 1) + 50'(c_reg[2]) + 50'(ROUND_HALF);
        wsum[3] = 50'(c_reg[3]) + 50'(ROUND_HALF);
        for (int i = 0; i < NUM_PTS; i++)
        begin
            w_next[i] = wsum[i][48:24];
        end

        for (int i = 0; i < NUM_PTS; i++)
        begin
            prodx_next[i] = $signed({1'b0, w_reg[i]}) * $signed(pts4_reg.x[i]);
            prody_next[i] = $signed({1'b0, w_reg[i]}) * $signed(pts4_reg.y[i]);
        end

        for (int j = 0; j < 2; j++)
        begin
            sumx_next[j] = 51'(prodx_reg[2*j]) + 51'(prodx_reg[2*j+1]);
            sumy_next[j] = 51'(prody_reg[2*j]) + 51'(prody_reg[2*j+1]);
        end

        accx = 52'(sumx_reg[0]) + 52'(sumx_reg[1]) + 52'(ROUND_HALF);
        accy = 52'(sumy_reg[0]) + 52'(sumy_reg[1]) + 52'(ROUND_HALF);
        if (past6_reg)
        begin
            point_x_next = '0;
            point_y_next = '0;
        end
        else
        begin
            point_x_next = sat_coord(accx[51:24]);
            point_y_next = sat_coord(accy[51:24]);
        end
    end

    // Control: valid bits and step size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            step_size_reg <= STEP_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                step_size_reg <= cfg_data;
            end
            if (stage_en[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            pts1_reg <= pts_in;
            t1_reg   <= t1_next;
        end
        if (stage_en[1])
        begin
            pts2_reg  <= pts1_reg;
            past2_reg <= past2_next;
            u2_reg    <= u2_next;
            t2_reg    <= t2_next;
            uu2_reg   <= uu2_next;
            tt2_reg   <= tt2_next;
        end
        if (stage_en[2])
        begin
            pts3_reg  <= pts2_reg;
            past3_reg <= past2_reg;
            c_reg     <= c_next;
        end
        if (stage_en[3])
        begin
            pts4_reg  <= pts3_reg;
            past4_reg <= past3_reg;
            w_reg     <= w_next;
        end
        if (stage_en[4])
        begin
            past5_reg <= past4_reg;
            prodx_reg <= prodx_next;
            prody_reg <= prody_next;
        end
        if (stage_en[5])
        begin
            past6_reg <= past5_reg;
            sumx_reg  <= sumx_next;
            sumy_reg  <= sumy_next;
        end
        if (stage_en[6])
        begin
            past7_reg   <= past6_reg;
            point_x_reg <= point_x_next;
            point_y_reg <= point_y_next;
        end
    end

    assign m_axis_tvalid = valid_reg[PIPE_DEPTH-1];
    assign m_axis_tdata  = {point_y_reg, point_x_reg};
    assign m_axis_tuser  = past7_reg;

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && (&valid_reg)))
        else $error("input stalled while the pipeline has room");

    a_past_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("past-end point is not zero");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> (step_size_reg == $past(cfg_data)))
        else $error("step size write lost");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (valid_reg[PIPE_DEPTH-1] && $stable(point_x_reg)
                                                && $stable(point_y_reg)))
        else $error("output stage moved during a stall");

endmodule
